/* rtl/core/fsa_pkg.sv */
// Shared types and constants of the fixed-slot free-list allocator.
package fsa_pkg;

   localparam int KIND_W   = 1;
   localparam int INDEX_W  = 9;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int CFG_W    = 9;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_FAULT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

/* rtl/core/fsa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module fsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fixed_slot_free_list_allocator.sv */
// Top level of the fixed-slot free-list allocator: control, head/tail state and RAMs.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_kind, req_slot_index
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_granted_slot, rsp_free_count
//   csr     | in        | csr_valid/csr_ready  | csr_active_slots
//
// The link and in-use RAMs are read when a request is accepted; the request is
// decided and written back in S_EXEC. One request is in work at a time.
// After reset and after every csr write a rebuild sweep writes one RAM entry
// per cycle over all MAX_SLOTS entries; req_ready is low during it.
// A result waiting on rsp_ready does not block acceptance of the next request;
// that request holds in S_EXEC until the output register frees.
module fixed_slot_free_list_allocator #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fsa_pkg::KIND_W-1:0]    req_kind,
   input  logic [fsa_pkg::INDEX_W-1:0]   req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fsa_pkg::GRANT_W-1:0]   rsp_granted_slot,
   output logic [fsa_pkg::COUNT_W-1:0]   rsp_free_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fsa_pkg::CFG_W-1:0]     csr_active_slots
);

   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > fsa_pkg::COUNT_W) ? CNT_W : fsa_pkg::COUNT_W;
   localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(MAX_SLOTS);
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(MAX_SLOTS - 1);

   fsa_pkg::state_type  state_ff, state_in;
   fsa_pkg::kind_type   kind_ff;
   logic [fsa_pkg::INDEX_W-1:0] index_ff;

   logic [CNT_W-1:0]  active_ff, active_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              empty_ff, empty_in;
   logic [IDX_W-1:0]  sweep_ff, sweep_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   fsa_pkg::status_type           rsp_status_ff;
   logic [fsa_pkg::GRANT_W-1:0]   rsp_granted_ff;
   logic [fsa_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic req_fire, csr_write, out_free, exec_fire, sweeping;

   logic [CMP_W-1:0]  cfg_ext, cfg_clamp, idx_ext, grant_ext, count_ext;
   logic [CNT_W-1:0]  cfg_value, cfg_minus_one;
   logic [IDX_W-1:0]  idx_addr, head_addr;
   fsa_pkg::status_type status_c;
   logic              alloc_ok, free_ok;

   logic              link_we, inuse_we, inuse_wdata, inuse_rd, rd_en;
   logic [IDX_W-1:0]  link_waddr, inuse_waddr, inuse_raddr;
   logic [LINK_W-1:0] link_wdata, link_rd, sweep_next;

   function automatic logic [IDX_W-1:0] idx_ext_rd(input logic [fsa_pkg::INDEX_W-1:0] idx);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(idx);
      return wide[IDX_W-1:0];
   endfunction

   // Handshakes and configuration value
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      cfg_ext = CMP_W'(csr_active_slots);
      if (cfg_ext == '0) begin
         cfg_clamp = CMP_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_SLOTS)) begin
         cfg_clamp = CMP_W'(MAX_SLOTS);
      end else begin
         cfg_clamp = cfg_ext;
      end
      cfg_value     = cfg_clamp[CNT_W-1:0];
      cfg_minus_one = cfg_value - CNT_W'(1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsa_pkg::S_INIT: begin
            if (sweep_ff == LAST_SLOT) begin
               state_in = fsa_pkg::S_IDLE;
            end
         end
         fsa_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = fsa_pkg::S_EXEC;
            end
         end
         fsa_pkg::S_EXEC: begin
            if (out_free) begin
               state_in = fsa_pkg::S_IDLE;
            end
         end
         default: state_in = fsa_pkg::S_INIT;
      endcase
      if (csr_write) begin
         state_in = fsa_pkg::S_INIT;
      end
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      sweeping  = 1'b0;
      exec_fire = 1'b0;
      unique case (state_ff)
         fsa_pkg::S_INIT: sweeping  = 1'b1;
         fsa_pkg::S_IDLE: req_ready = 1'b1;
         fsa_pkg::S_EXEC: exec_fire = out_free;
         default: ;
      endcase
   end

   // Request decision
   assign idx_ext   = CMP_W'(index_ff);
   assign idx_addr  = idx_ext[IDX_W-1:0];
   assign head_addr = head_ff[IDX_W-1:0];

   always_comb begin
      status_c = fsa_pkg::ST_OK;
      if (kind_ff == fsa_pkg::KIND_ALLOC) begin
         if (count_ff == '0) begin
            status_c = fsa_pkg::ST_NOMEM;
         end else if (empty_ff || head_ff >= END_MARK || inuse_rd) begin
            status_c = fsa_pkg::ST_FAULT;
         end
      end else begin
         if (idx_ext >= CMP_W'(active_ff)) begin
            status_c = fsa_pkg::ST_INVALID;
         end else if (!inuse_rd) begin
            status_c = fsa_pkg::ST_FAULT;
         end
      end
      alloc_ok = exec_fire && (kind_ff == fsa_pkg::KIND_ALLOC) && (status_c == fsa_pkg::ST_OK);
      free_ok  = exec_fire && (kind_ff == fsa_pkg::KIND_FREE) && (status_c == fsa_pkg::ST_OK);
   end

   // Pool state update
   always_comb begin
      active_in = active_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      empty_in  = empty_ff;
      sweep_in  = sweep_ff;
      if (csr_write) begin
         active_in = cfg_value;
         head_in   = '0;
         tail_in   = cfg_minus_one[IDX_W-1:0];
         count_in  = cfg_value;
         empty_in  = 1'b0;
         sweep_in  = '0;
      end else begin
         if (sweeping) begin
            sweep_in = sweep_ff + IDX_W'(1);
         end
         if (alloc_ok) begin
            count_in = count_ff - CNT_W'(1);
            if (link_rd >= END_MARK) begin
               empty_in = 1'b1;
               head_in  = '0;
            end else begin
               head_in = link_rd;
            end
         end
         if (free_ok) begin
            if (empty_ff) begin
               head_in  = LINK_W'(idx_addr);
               empty_in = 1'b0;
            end
            tail_in  = idx_addr;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // RAM ports
   assign sweep_next  = LINK_W'(sweep_ff) + LINK_W'(1);
   assign rd_en       = req_fire;
   assign inuse_raddr = (fsa_pkg::kind_type'(req_kind) == fsa_pkg::KIND_FREE)
                        ? idx_ext_rd(req_slot_index) : head_addr;

   always_comb begin
      link_we     = 1'b0;
      link_waddr  = head_addr;
      link_wdata  = END_MARK;
      inuse_we    = 1'b0;
      inuse_waddr = head_addr;
      inuse_wdata = 1'b0;
      if (sweeping) begin
         link_we     = 1'b1;
         link_waddr  = sweep_ff;
         link_wdata  = (sweep_next < LINK_W'(active_ff)) ? sweep_next : END_MARK;
         inuse_we    = 1'b1;
         inuse_waddr = sweep_ff;
         inuse_wdata = 1'b0;
      end else if (alloc_ok) begin
         link_we     = 1'b1;
         inuse_we    = 1'b1;
         inuse_wdata = 1'b1;
      end else if (free_ok) begin
         link_we     = ~empty_ff;
         link_waddr  = tail_ff;
         link_wdata  = LINK_W'(idx_addr);
         inuse_we    = 1'b1;
         inuse_waddr = idx_addr;
         inuse_wdata = 1'b0;
      end
   end

   fsa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (rd_en),
      .rd_addr (head_addr),
      .rd_data (link_rd)
   );

   fsa_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLOTS)
   ) u_inuse_ram (
      .clock   (clock),
      .wr_en   (inuse_we),
      .wr_addr (inuse_waddr),
      .wr_data (inuse_wdata),
      .rd_en   (rd_en),
      .rd_addr (inuse_raddr),
      .rd_data (inuse_rd)
   );

   // Result register
   assign grant_ext    = alloc_ok ? CMP_W'(head_addr) : '0;
   assign count_ext    = CMP_W'(count_in);
   assign rsp_valid_in = exec_fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsa_pkg::S_INIT;
         active_ff    <= CNT_W'(MAX_SLOTS);
         head_ff      <= '0;
         tail_ff      <= LAST_SLOT;
         count_ff     <= CNT_W'(MAX_SLOTS);
         empty_ff     <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         empty_ff     <= empty_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= fsa_pkg::kind_type'(req_kind);
         index_ff <= req_slot_index;
      end
      if (exec_fire) begin
         rsp_status_ff  <= status_c;
         rsp_granted_ff <= grant_ext[fsa_pkg::GRANT_W-1:0];
         rsp_count_ff   <= count_ext[fsa_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_free_count   = rsp_count_ff;

endmodule

/* rtl/core/fsa_checker.sv */
// Port-level assertions for the fixed-slot free-list allocator, with its bind.
module fsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [fsa_pkg::KIND_W-1:0]    req_kind,
   input logic [fsa_pkg::INDEX_W-1:0]   req_slot_index,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fsa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [fsa_pkg::GRANT_W-1:0]   rsp_granted_slot,
   input logic [fsa_pkg::COUNT_W-1:0]   rsp_free_count,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [fsa_pkg::CFG_W-1:0]     csr_active_slots
);

   a_grant_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == fsa_pkg::ST_OK || rsp_granted_slot == '0))
      else $error("granted slot set on a failed or free request");

   a_nomem_means_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fsa_pkg::ST_NOMEM |-> rsp_free_count == '0)
      else $error("no-memory status with nonzero free count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous request still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_slot) && $stable(rsp_free_count))
      else $error("stalled response changed");

endmodule

bind fixed_slot_free_list_allocator fsa_checker u_fsa_checker (.*);
